>>> src/assert_macros.svh
// Concurrent check helpers, clocked on aclk and idle during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");

`endif

>>> src/adsr_pkg.sv
package adsr_pkg;

    localparam int OUTPUT_BITS        = 16;
    localparam int SINE_DEPTH_DEFAULT = 1024;
    localparam int LEVEL_W            = 16;
    localparam int CNT_W              = 24;
    localparam int NUM_W              = LEVEL_W + CNT_W;
    localparam int QUO_W              = LEVEL_W;
    localparam int CFG_IDX_W          = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WAVEFORM, REG_PHASE_STEP, REG_PULSE_WIDTH, REG_PEAK,
        REG_SUSTAIN, REG_ATTACK, REG_DECAY, REG_RELEASE
    } cfg_reg_t;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_TICK  = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        WAVE_SINE, WAVE_TRIANGLE, WAVE_SAW, WAVE_PULSE
    } wave_t;

    typedef struct packed {
        logic             req_type;
        logic [CNT_W-1:0] note_length;
    } synth_in_t;

    typedef struct packed {
        logic signed [OUTPUT_BITS-1:0] sample;
        logic [LEVEL_W-1:0]            envelope_level;
        logic                          last_sample;
    } synth_out_t;

endpackage

>>> src/adsr_sine_rom.sv
module adsr_sine_rom #(
    parameter int DEPTH = adsr_pkg::SINE_DEPTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic [$clog2(DEPTH+1)-1:0] rd_addr,
    output logic [15:0]                rd_data
);
    import adsr_pkg::*;

    typedef logic [15:0] rom_t [DEPTH+1];

    localparam longint COEF [5] = '{
        64'sd1686629713, -64'sd693598668, 64'sd85569306, -64'sd5026995, 64'sd172272
    };

    // Q30 product, magnitude truncated toward zero
    function automatic longint mul_q30(longint a, longint b);
        logic   neg;
        longint ma;
        longint mb;
        longint m;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        m   = (ma * mb) >> 30;
        return neg ? -m : m;
    endfunction

    function automatic rom_t build_rom();
        rom_t   r;
        longint t;
        longint t2;
        longint s;
        longint v;
        for (int m = 0; m <= DEPTH; m++) begin
            t  = (longint'(m) <<< 30) / DEPTH;
            t2 = mul_q30(t, t);
            s  = COEF[4];
            for (int j = 3; j >= 0; j--) begin
                s = COEF[j] + mul_q30(s, t2);
            end
            s = mul_q30(s, t);
            if (s <= 0) begin
                r[m] = 16'd0;
            end else begin
                v = (s * 64'sd32768 + 64'sd536870912) >> 30;
                if (v > 64'sd32768) begin
                    v = 64'sd32768;
                end
                r[m] = v[15:0];
            end
        end
        return r;
    endfunction

    localparam rom_t ROM = build_rom();

    always_ff @(posedge aclk) begin
        rd_data <= ROM[rd_addr];
    end

endmodule

>>> src/adsr_div.sv
// Restoring divider, one quotient bit per cycle. Caller guarantees
// num < den << QUO_W so the quotient fits.
module adsr_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [adsr_pkg::NUM_W-1:0]  num,
    input  logic [adsr_pkg::CNT_W-1:0]  den,
    output logic                        done,
    output logic [adsr_pkg::QUO_W-1:0]  quo
);
    import adsr_pkg::*;

    localparam int CW = $clog2(QUO_W + 1);

    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] den_reg;
    logic [QUO_W-1:0] bits_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, bits_reg[QUO_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= num[NUM_W-1:QUO_W];
                bits_reg <= num[QUO_W-1:0];
                den_reg  <= den;
                cnt_reg  <= CW'(QUO_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= fits ? CNT_W'(trial - {1'b0, den_reg}) : trial[CNT_W-1:0];
                bits_reg <= {bits_reg[QUO_W-2:0], fits};
                cnt_reg  <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = bits_reg;

endmodule

>>> src/adsr_waveform_synth.sv
// Channel  Ports                     Moves
// -------  ------------------------  ---------------------------------------
// input    s_valid s_ready s_data    start (note length) or sample tick
// output   m_valid m_ready m_data    sample, envelope level, last flag
// config   cfg_we cfg_index cfg_wdata register write, no handshake
//
// Start transactions and ticks past note end stay in S_IDLE. A ramp tick
// (attack, decay, release) runs S_SETUP, S_START, S_DIV with its 16-step
// serial envelope divider, S_SCALE and S_FIN; flat ticks skip S_DIV.
// Synchronous active-low reset; state and config registers get defaults.
// The output register holds a result while the next tick is computed;
// only the final cycle waits for m_ready.
`include "assert_macros.svh"

module adsr_waveform_synth #(
    parameter int SINE_TABLE_DEPTH = adsr_pkg::SINE_DEPTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [adsr_pkg::CNT_W-1:0]      cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  adsr_pkg::synth_in_t             s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output adsr_pkg::synth_out_t            m_data
);
    import adsr_pkg::*;

    localparam int AW  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int KPW = 22 + AW;
    localparam int PW  = 33;
    localparam int SW  = PW + OUTPUT_BITS - 1;
    localparam logic [SW-1:0] FULL = SW'((64'd1 << (OUTPUT_BITS - 1)) - 64'd1);

    typedef enum logic [2:0] {S_IDLE, S_SETUP, S_START, S_DIV, S_SCALE, S_FIN} state_t;
    typedef enum logic [1:0] {SEG_ATTACK, SEG_DECAY, SEG_RELEASE, SEG_FLAT} seg_t;

    state_t state_reg;
    seg_t   seg_reg;

    wave_t              waveform_reg;
    logic [CNT_W-1:0]   phase_step_reg;
    logic [15:0]        pulse_width_reg;
    logic [LEVEL_W-1:0] peak_reg;
    logic [LEVEL_W-1:0] sustain_reg;
    logic [CNT_W-1:0]   attack_reg;
    logic [CNT_W-1:0]   decay_reg;
    logic [CNT_W-1:0]   release_reg;

    logic [CNT_W-1:0]   sample_index_reg;
    logic [CNT_W-1:0]   note_total_reg;
    logic [CNT_W-1:0]   phase_acc_reg;
    logic [LEVEL_W-1:0] held_level_reg;

    logic [LEVEL_W-1:0] mul_a_reg;
    logic [CNT_W-1:0]   mul_b_reg;
    logic [CNT_W-1:0]   den_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [AW-1:0]      rom_addr_reg;
    logic [PW-1:0]      prod_reg;
    logic               neg_reg;
    logic               m_valid_reg;
    synth_out_t         out_reg;

    logic               div_start;
    logic               div_done;
    logic [QUO_W-1:0]   div_quo;
    logic [15:0]        rom_data;

    logic               in_attack;
    logic               in_decay;
    logic               in_flat;
    logic               sus_ge_peak;
    logic [KPW-1:0]     kprod;
    logic [AW-1:0]      k_idx;
    logic [25:0]        four_d;
    logic [CNT_W-1:0]   tri_d;
    logic [16:0]        osc_mag;
    logic               osc_neg;
    logic [SW-1:0]      big;
    logic [SW-1:0]      scaled;
    logic [OUTPUT_BITS-1:0] mag_out;
    logic               fin_load;

    adsr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (NUM_W'(mul_a_reg * mul_b_reg)),
        .den     (den_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    adsr_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom (
        .aclk    (aclk),
        .rd_addr (rom_addr_reg),
        .rd_data (rom_data)
    );

    assign s_ready   = state_reg == S_IDLE;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign div_start = (state_reg == S_START) && (seg_reg != SEG_FLAT);
    assign fin_load  = (state_reg == S_FIN) && (!m_valid_reg || m_ready);

    // segment select
    assign in_attack   = sample_index_reg <= attack_reg;
    assign in_decay    = {1'b0, sample_index_reg} <= ({1'b0, attack_reg} + {1'b0, decay_reg});
    assign in_flat     = ({1'b0, sample_index_reg} + {1'b0, release_reg}) <=
                         {1'b0, note_total_reg};
    assign sus_ge_peak = sustain_reg >= peak_reg;

    // quarter-wave table address
    assign kprod = KPW'(phase_acc_reg[21:0]) * KPW'(SINE_TABLE_DEPTH);
    assign k_idx = kprod[KPW-1:22];

    // oscillator as sign and magnitude
    assign tri_d  = phase_acc_reg[23] ? CNT_W'(25'h1000000 - {1'b0, phase_acc_reg})
                                      : phase_acc_reg;
    assign four_d = {tri_d, 2'b00};

    always_comb begin
        osc_mag = '0;
        osc_neg = 1'b0;
        case (waveform_reg)
            WAVE_SINE: begin
                osc_mag = {1'b0, rom_data};
                osc_neg = phase_acc_reg[23];
            end
            WAVE_TRIANGLE: begin
                if (four_d >= 26'h1000000) begin
                    osc_mag = 17'((four_d - 26'h1000000) >> 9);
                end else begin
                    osc_mag = 17'((26'h1000000 - four_d) >> 9);
                    osc_neg = 1'b1;
                end
            end
            WAVE_SAW: begin
                if (!phase_acc_reg[23]) begin
                    osc_mag = 17'(phase_acc_reg >> 8);
                end else begin
                    osc_mag = 17'((25'h1000000 - {1'b0, phase_acc_reg}) >> 8);
                    osc_neg = 1'b1;
                end
            end
            WAVE_PULSE: begin
                osc_mag = 17'h08000;
                osc_neg = !(phase_acc_reg < {pulse_width_reg, 8'h00});
            end
            default: begin
                osc_mag = '0;
                osc_neg = 1'b0;
            end
        endcase
    end

    // times (2^(B-1)-1) as shift and subtract, then >> 30 and saturate
    assign big     = {prod_reg, {(OUTPUT_BITS-1){1'b0}}} - SW'(prod_reg);
    assign scaled  = big >> 30;
    assign mag_out = (scaled > FULL) ? FULL[OUTPUT_BITS-1:0] : scaled[OUTPUT_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            seg_reg          <= SEG_FLAT;
            m_valid_reg      <= 1'b0;
            waveform_reg     <= WAVE_SINE;
            phase_step_reg   <= '0;
            pulse_width_reg  <= 16'd32768;
            peak_reg         <= 16'd32768;
            sustain_reg      <= 16'd16384;
            attack_reg       <= '0;
            decay_reg        <= '0;
            release_reg      <= '0;
            sample_index_reg <= '0;
            note_total_reg   <= '0;
            phase_acc_reg    <= '0;
            held_level_reg   <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_WAVEFORM:    waveform_reg    <= wave_t'(cfg_wdata[1:0]);
                    REG_PHASE_STEP:  phase_step_reg  <= cfg_wdata;
                    REG_PULSE_WIDTH: pulse_width_reg <= cfg_wdata[15:0];
                    REG_PEAK:        peak_reg        <= cfg_wdata[15:0];
                    REG_SUSTAIN:     sustain_reg     <= cfg_wdata[15:0];
                    REG_ATTACK:      attack_reg      <= cfg_wdata;
                    REG_DECAY:       decay_reg       <= cfg_wdata;
                    REG_RELEASE:     release_reg     <= cfg_wdata;
                    default: ;
                endcase
            end

            if (m_valid_reg && m_ready && !fin_load) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        if (req_t'(s_data.req_type) == REQ_START) begin
                            note_total_reg   <= s_data.note_length;
                            sample_index_reg <= '0;
                            phase_acc_reg    <= '0;
                            held_level_reg   <= '0;
                        end else if (sample_index_reg < note_total_reg) begin
                            state_reg <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    rom_addr_reg <= phase_acc_reg[22] ? AW'(SINE_TABLE_DEPTH) - k_idx : k_idx;
                    if (in_attack) begin
                        if (attack_reg == '0) begin
                            seg_reg   <= SEG_FLAT;
                            level_reg <= peak_reg;
                        end else begin
                            seg_reg   <= SEG_ATTACK;
                            mul_a_reg <= peak_reg;
                            mul_b_reg <= sample_index_reg;
                            den_reg   <= attack_reg;
                        end
                    end else if (in_decay) begin
                        seg_reg   <= SEG_DECAY;
                        mul_a_reg <= sus_ge_peak ? sustain_reg - peak_reg
                                                 : peak_reg - sustain_reg;
                        mul_b_reg <= sample_index_reg - attack_reg;
                        den_reg   <= decay_reg;
                    end else if (in_flat) begin
                        seg_reg   <= SEG_FLAT;
                        level_reg <= held_level_reg;
                    end else begin
                        seg_reg   <= SEG_RELEASE;
                        mul_a_reg <= sustain_reg;
                        mul_b_reg <= note_total_reg - sample_index_reg;
                        den_reg   <= release_reg;
                    end
                    state_reg <= S_START;
                end
                S_START: begin
                    state_reg <= (seg_reg == SEG_FLAT) ? S_SCALE : S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        if (seg_reg == SEG_DECAY) begin
                            level_reg <= sus_ge_peak ? peak_reg + div_quo : peak_reg - div_quo;
                        end else begin
                            level_reg <= div_quo;
                        end
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    prod_reg  <= PW'(osc_mag * level_reg);
                    neg_reg   <= osc_neg;
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (fin_load) begin
                        out_reg.sample         <= neg_reg ? -mag_out : mag_out;
                        out_reg.envelope_level <= level_reg;
                        out_reg.last_sample    <= ({1'b0, sample_index_reg} + 25'd1) ==
                                                  {1'b0, note_total_reg};
                        m_valid_reg      <= 1'b1;
                        held_level_reg   <= level_reg;
                        sample_index_reg <= sample_index_reg + CNT_W'(1);
                        phase_acc_reg    <= phase_acc_reg + phase_step_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_div_done_in_div, div_done, state_reg == S_DIV)
    `ASSERT_IMPL(a_tick_inside_note, state_reg == S_SETUP, sample_index_reg < note_total_reg)
    `ASSERT_NEXT(a_index_steps, fin_load, sample_index_reg == $past(sample_index_reg) + 24'd1)

endmodule

>>> sim/adsr_checker.sv
module adsr_checker
    import adsr_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  synth_in_t            s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  synth_out_t           m_data,
    output int                   n_errors,
    output int                   n_pending
);

    localparam longint unsigned FULL = (64'd1 << (OUTPUT_BITS - 1)) - 1;

    // Q30 sine polynomial, odd powers
    localparam longint SIN_C0 = 1686629713;
    localparam longint SIN_C1 = -693598668;
    localparam longint SIN_C2 = 85569306;
    localparam longint SIN_C3 = -5026995;
    localparam longint SIN_C4 = 172272;

    wave_t              wave_sel;
    logic [CNT_W-1:0]   phase_inc;
    logic [15:0]        pulse_frac;
    logic [15:0]        peak;
    logic [15:0]        sustain;
    logic [CNT_W-1:0]   attack_len;
    logic [CNT_W-1:0]   decay_len;
    logic [CNT_W-1:0]   release_len;

    logic [CNT_W-1:0]   note_pos;
    logic [CNT_W-1:0]   note_len;
    logic [CNT_W-1:0]   phase;
    logic [15:0]        last_level;

    synth_out_t         sample_q[$];

    assign n_pending = sample_q.size();

    function automatic longint qmul(longint a, longint b);
        longint unsigned ma, mb, m;
        bit neg;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        m = (ma * mb) >> 30;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic int sine_lookup(int unsigned m);
        longint t, t2, s;
        longint unsigned v;
        t = longint'((longint'(m) << 30) / SINE_TABLE_DEPTH);
        t2 = qmul(t, t);
        s = SIN_C4;
        s = SIN_C3 + qmul(s, t2);
        s = SIN_C2 + qmul(s, t2);
        s = SIN_C1 + qmul(s, t2);
        s = SIN_C0 + qmul(s, t2);
        s = qmul(s, t);
        if (s <= 0) return 0;
        v = (longint'(s) * 32768 + (64'd1 << 29)) >> 30;
        if (v > 32768) v = 32768;
        return int'(v);
    endfunction

    function automatic int osc_value(logic [CNT_W-1:0] p);
        int unsigned q, k, m;
        longint d;
        int v;
        case (wave_sel)
            WAVE_SINE: begin
                q = p >> 22;
                k = int'((longint'(p & 24'h3FFFFF) * SINE_TABLE_DEPTH) >> 22);
                m = (q & 1) ? SINE_TABLE_DEPTH - k : k;
                v = sine_lookup(m);
                return (q & 2) ? -v : v;
            end
            WAVE_TRIANGLE: begin
                d = (p < 24'h800000) ? longint'(p) : 64'sh1000000 - longint'(p);
                return int'((4 * d - 64'sh1000000) / 512);
            end
            WAVE_SAW: begin
                if (p < 24'h800000) return int'(p >> 8);
                return int'((longint'(p) - 64'sh1000000) / 256);
            end
            default: return (longint'(p) < (longint'(pulse_frac) << 8)) ? 32768 : -32768;
        endcase
    endfunction

    function automatic longint unsigned env_level();
        longint unsigned i, a, d, r, n, pk, su;
        i = note_pos; a = attack_len; d = decay_len; r = release_len;
        n = note_len; pk = peak; su = sustain;
        if (i <= a) return (a == 0) ? pk : pk * i / a;
        if (i <= a + d) begin
            if (d == 0) return su;
            if (su >= pk) return pk + (su - pk) * (i - a) / d;
            return pk - (pk - su) * (i - a) / d;
        end
        if (i + r <= n) return last_level;
        if (r == 0 || i >= n) return 0;
        return su * (n - i) / r;
    endfunction

    task automatic predict_tick();
        logic [15:0] lvl;
        int o;
        longint unsigned mag;
        synth_out_t exp_s;
        if (note_pos >= note_len) return;
        lvl = env_level();
        last_level = lvl;
        o = osc_value(phase);
        mag = (longint'(o < 0 ? -o : o) * lvl * FULL) >> 30;
        if (mag > FULL) mag = FULL;
        exp_s.sample = (o < 0) ? -mag[OUTPUT_BITS-1:0] : mag[OUTPUT_BITS-1:0];
        exp_s.envelope_level = lvl;
        exp_s.last_sample = (note_pos + 24'd1 == note_len);
        sample_q.insert(sample_q.size(), exp_s);
        note_pos = note_pos + 24'd1;
        phase = phase + phase_inc;
    endtask

    task automatic report(string what, int exp_v, int act_v);
        n_errors++;
        if (n_errors <= 10)
            $display("mismatch %s: expected %0d actual %0d", what, exp_v, act_v);
    endtask

    always @(posedge aclk) begin
        synth_out_t exp_s;
        if (!aresetn) begin
            wave_sel = WAVE_SINE;
            phase_inc = '0;
            pulse_frac = 16'd32768;
            peak = 16'd32768;
            sustain = 16'd16384;
            attack_len = '0;
            decay_len = '0;
            release_len = '0;
            note_pos = '0;
            note_len = '0;
            phase = '0;
            last_level = '0;
            sample_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_WAVEFORM:    wave_sel = wave_t'(cfg_wdata[1:0]);
                    REG_PHASE_STEP:  phase_inc = cfg_wdata;
                    REG_PULSE_WIDTH: pulse_frac = cfg_wdata[15:0];
                    REG_PEAK:        peak = cfg_wdata[15:0];
                    REG_SUSTAIN:     sustain = cfg_wdata[15:0];
                    REG_ATTACK:      attack_len = cfg_wdata;
                    REG_DECAY:       decay_len = cfg_wdata;
                    REG_RELEASE:     release_len = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (req_t'(s_data.req_type) == REQ_START) begin
                    note_len = s_data.note_length;
                    note_pos = '0;
                    phase = '0;
                    last_level = '0;
                end else begin
                    predict_tick();
                end
            end
            if (m_valid && m_ready) begin
                if (sample_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected transaction: sample %0d level %0d last %0d",
                                 m_data.sample, m_data.envelope_level, m_data.last_sample);
                end else begin
                    exp_s = sample_q.pop_front();
                    if (m_data.sample !== exp_s.sample)
                        report("sample", exp_s.sample, m_data.sample);
                    if (m_data.envelope_level !== exp_s.envelope_level)
                        report("envelope_level", exp_s.envelope_level, m_data.envelope_level);
                    if (m_data.last_sample !== exp_s.last_sample)
                        report("last_sample", exp_s.last_sample, m_data.last_sample);
                end
            end
        end
    end

    initial n_errors = 0;

endmodule

>>> sim/tb_adsr_waveform_synth.sv
module tb_adsr_waveform_synth;
    import adsr_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 1650;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    synth_in_t            s_data;
    logic                 m_valid;
    logic                 m_ready;
    synth_out_t           m_data;

    int n_errors;
    int n_pending;
    int items_sent;
    int idle_cycles;
    bit hold_off;
    bit in_random;

    adsr_waveform_synth i_dut (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_wdata,
        .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data
    );

    adsr_checker i_checker (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_wdata,
        .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .n_errors, .n_pending
    );

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    // receiver stall pattern: a random mode, redrawn when the countdown runs out
    int rx_mode;
    int rx_count;
    always @(negedge aclk) begin
        if (rx_count == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_count <= 64;
        end else begin
            rx_count <= rx_count - 1;
        end
        if (hold_off)
            m_ready <= 1'b0;
        else case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 9) == 0);
            default: m_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // one long receiver hold-off during the random part
    initial begin
        hold_off = 1'b0;
        wait (in_random);
        repeat (2000) @(negedge aclk);
        hold_off = 1'b1;
        repeat (400) @(negedge aclk);
        hold_off = 1'b0;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_adsr_waveform_synth: FAIL");
            $finish;
        end
    end

    // offer one transaction; valid stays high when the next follows directly
    task automatic send(req_t req, logic [CNT_W-1:0] len);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data.req_type <= req;
        s_data.note_length <= len;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if ($urandom_range(0, 7) == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 20)) @(negedge aclk);
        end
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CNT_W-1:0] val);
        @(negedge aclk);
        s_valid <= 1'b0;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (n_pending == 0);
        repeat (40) @(negedge aclk);
    endtask

    task automatic end_writes();
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CNT_W-1:0] rand_len(int hi);
        case ($urandom_range(0, 9))
            0: return 24'hFFFFFF;
            1: return CNT_W'($urandom_range(0, 24'hFFFFFF));
            2: return '0;
            default: return CNT_W'($urandom_range(0, hi));
        endcase
    endfunction

    function automatic logic [15:0] rand_level();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'($urandom_range(32769, 65535));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic random_config();
        write_reg(REG_WAVEFORM, CNT_W'($urandom_range(0, 3)));
        write_reg(REG_PHASE_STEP, ($urandom_range(0, 3) == 0) ?
                  24'($urandom_range(0, 24'hFFFFFF)) : 24'($urandom_range(0, 24'h0FFFFF)));
        write_reg(REG_PULSE_WIDTH, ($urandom_range(0, 5) == 0) ?
                  (($urandom_range(0, 1) == 1) ? 24'h00FFFF : 24'h000000) :
                  24'($urandom_range(0, 65535)));
        write_reg(REG_PEAK, CNT_W'(rand_level()));
        write_reg(REG_SUSTAIN, CNT_W'(rand_level()));
        write_reg(REG_ATTACK, rand_len(20));
        write_reg(REG_DECAY, rand_len(20));
        write_reg(REG_RELEASE, rand_len(20));
        end_writes();
    endtask

    initial begin
        int n_ticks;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        rx_mode = 0;
        rx_count = 0;
        items_sent = 0;
        idle_cycles = 0;
        in_random = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: tick before any start, zero-length note, defaults
        send(REQ_TICK, '0);
        send(REQ_START, '0);
        send(REQ_TICK, 24'hFFFFFF);
        send(REQ_START, 24'd4);
        repeat (5) send(REQ_TICK, '0);
        settle();
        // every waveform with ramps; release longer than the note on the triangle
        for (int w = WAVE_SINE; w <= WAVE_PULSE; w++) begin
            write_reg(REG_WAVEFORM, CNT_W'(w));
            write_reg(REG_PHASE_STEP, 24'h0C0001);
            write_reg(REG_PULSE_WIDTH, 24'h004000);
            write_reg(REG_PEAK, (w == WAVE_PULSE) ? 24'h00FFFF : 24'd32768);
            write_reg(REG_SUSTAIN, 24'd20000);
            write_reg(REG_ATTACK, 24'd1);
            write_reg(REG_DECAY, 24'd1);
            write_reg(REG_RELEASE, (w == WAVE_TRIANGLE) ? 24'd9 : 24'd1);
            end_writes();
            send(REQ_START, 24'd4);
            repeat (4) send(REQ_TICK, '0);
            settle();
        end

        in_random = 1'b1;
        while (items_sent < RANDOM_ITEMS - 50) begin
            random_config();
            repeat ($urandom_range(3, 8)) begin
                if ($urandom_range(0, 9) == 0) begin
                    send(req_t'($urandom_range(0, 1)), 24'($urandom_range(0, 24'hFFFFFF)));
                end else begin
                    send(REQ_START, rand_len(40));
                    n_ticks = $urandom_range(0, 45);
                    repeat (n_ticks) send(REQ_TICK, 24'($urandom_range(0, 24'hFFFFFF)));
                end
            end
            settle();
        end

        wait (n_pending == 0);
        repeat (50) @(posedge aclk);
        if (n_errors == 0)
            $display("tb_adsr_waveform_synth: PASS");
        else
            $display("tb_adsr_waveform_synth: FAIL");
        $finish;
    end

endmodule
